// ===== rtl/core/alpl_pkg.sv =====
// ----------------------------------------------------------------------------
// alpl_pkg
// Shared types and codes for the arc-length parameter lookup block.
// ----------------------------------------------------------------------------
package alpl_pkg;

	localparam int DistW  = 32;
	localparam int ParamW = 32;
	localparam int StatW  = 3;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	localparam logic [1:0] REG_TOTAL_LENGTH = 2'd0;
	localparam logic [1:0] REG_ENTRY_COUNT  = 2'd1;
	localparam logic [1:0] REG_EPSILON      = 2'd2;

	// result status codes
	localparam logic [StatW-1:0] ST_INTERP   = 3'd0;
	localparam logic [StatW-1:0] ST_FIRST    = 3'd1;
	localparam logic [StatW-1:0] ST_LAST     = 3'd2;
	localparam logic [StatW-1:0] ST_EMPTY    = 3'd3;
	localparam logic [StatW-1:0] ST_ZERO_LEN = 3'd4;
	localparam logic [StatW-1:0] ST_WRITE    = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRAP,
		S_CHK,
		S_CMP,
		S_POST,
		S_RDP,
		S_RDA,
		S_RDB,
		S_MUL,
		S_DIV,
		S_DIVW
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// ===== rtl/core/alpl_table.sv =====
// ----------------------------------------------------------------------------
// alpl_table
// Sample table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alpl_table #(
	parameter int Depth = 1024,
	parameter int AddrW = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [63:0]      wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [63:0]      rdata
);
	import alpl_pkg::*;

	logic [63:0] mem_q [Depth];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/alpl_div.sv =====
// ----------------------------------------------------------------------------
// alpl_div
// Restoring radix-2 divider, 64/32, one quotient bit per cycle.
// Caller guarantees dividend[63:32] < divisor.
// ----------------------------------------------------------------------------
module alpl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  alpl_pkg::div_ctl_t  ctl_in,
	input  logic [63:0]         dividend,
	input  logic [31:0]         divisor,
	output alpl_pkg::div_ctl_t  ctl_out,
	output logic [31:0]         quotient,
	output logic [31:0]         remainder
);
	import alpl_pkg::*;

	logic [63:0] acc_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [64:0] sh;
	logic [32:0] top;
	logic        ge;

	always_comb begin
		sh  = {acc_q, 1'b0};
		ge  = sh[64:32] >= {1'b0, div_q};
		top = ge ? (sh[64:32] - {1'b0, div_q}) : sh[64:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			acc_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			acc_q <= {top[31:0], sh[31:1], ge};
		end
	end

	assign ctl_out.start = run_q;
	assign ctl_out.done  = done_q;
	assign quotient      = acc_q[31:0];
	assign remainder     = acc_q[63:32];

endmodule

// ===== rtl/core/arc_length_param_lookup.sv =====
// ----------------------------------------------------------------------------
// arc_length_param_lookup
// Inverse arc-length lookup: wraps a query distance by the track length,
// binary-searches a sorted (distance, parameter) table and interpolates.
// ----------------------------------------------------------------------------
//
// Channel    Signals                                         Handshake
// command    start, busy, command, entry_*, query_distance   start && !busy
// result     done, param_out, status                         done, one cycle
// config     cfg_we, cfg_index, cfg_wdata                    cfg_we
//
// A write transaction is accepted without leaving idle; done is registered,
// so the result strobes the next cycle, and busy never rises, so a new
// transaction can be taken at once. A query runs the wrap divider, a binary
// search (a memory read then a compare per step), the endpoint reads, a
// multiply and the divider; early cases (empty, zero length, clamps) finish
// sooner. The serial divider and the registered memory read set this time.
// Reset clears control and config (epsilon to 1); table contents stay undefined.
// The receiver cannot stall: done is a single-cycle strobe.
module arc_length_param_lookup #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [9:0]                    entry_index,
	input  logic [alpl_pkg::DistW-1:0]    entry_distance,
	input  logic [alpl_pkg::ParamW-1:0]   entry_param,
	input  logic signed [31:0]            query_distance,
	output logic                          done,
	output logic [alpl_pkg::ParamW-1:0]   param_out,
	output logic [alpl_pkg::StatW-1:0]    status,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_wdata
);
	import alpl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// configuration
	logic [31:0] total_length_q;
	logic [10:0] entry_count_q;
	logic [15:0] epsilon_q;

	// control / datapath
	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, lo_q, hi_q, mid;
	logic [31:0]      query_q;
	logic [31:0]      r_q;
	logic [31:0]      d0_q, p0_q;
	logic [31:0]      delta_q, num_q, gap_q;
	logic [63:0]      prod_q;
	logic             down_q;
	logic [StatW-1:0] stat_pend_q;
	logic             done_q;
	logic [31:0]      param_q;
	logic [StatW-1:0] status_q;

	logic             accept;
	logic [31:0]      count_clamp;
	logic [CW-1:0]    count_in;
	logic [AW-1:0]    raddr;
	logic             wr_en;
	logic [63:0]      rdata;
	logic [31:0]      rd_dist, rd_param;
	logic [31:0]      mag;
	div_ctl_t         div_in, div_out;
	logic [63:0]      div_dvd;
	logic [31:0]      div_dsr, div_quo, div_rem;
	logic [31:0]      gap_now;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign rd_dist  = rdata[63:32];
	assign rd_param = rdata[31:0];
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign gap_now  = rd_dist - d0_q;
	// two's-complement magnitude; the most negative value maps to 2^31 itself
	assign mag      = ~query_q + 32'd1;

	always_comb begin
		count_clamp = ({21'b0, entry_count_q} > 32'(TABLE_DEPTH)) ?
			32'(TABLE_DEPTH) : {21'b0, entry_count_q};
		count_in = count_clamp[CW-1:0];
	end

	// table writes go straight from the ports on accept
	assign wr_en = accept && (command == CMD_WRITE) &&
		({22'b0, entry_index} < 32'(TABLE_DEPTH));

	alpl_table #(
		.Depth (TABLE_DEPTH),
		.AddrW (AW)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'({22'b0, entry_index})),
		.wdata ({entry_distance, entry_param}),
		.raddr (raddr),
		.rdata (rdata)
	);

	alpl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (div_in),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.ctl_out   (div_out),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state, memory address and divider launch
	always_comb begin
		state_d      = state_q;
		raddr        = '0;
		div_in.start = 1'b0;
		div_in.done  = 1'b0;
		div_dvd      = {32'b0, query_q[31] ? mag : query_q};
		div_dsr      = total_length_q;
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_QUERY) begin
					if (count_in == '0) begin
						state_d = S_IDLE;
					end else if (total_length_q <= {16'b0, epsilon_q}) begin
						state_d = S_RDP;
					end else begin
						state_d = S_WRAP;
					end
				end
			end
			S_WRAP: begin
				// launch on first cycle: divider not yet running
				div_in.start = !div_out.start && !div_out.done;
				if (div_out.done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				raddr = mid[AW-1:0];
				state_d = (lo_q < hi_q) ? S_CMP : S_POST;
			end
			S_CMP: begin
				state_d = S_CHK;
			end
			S_POST: begin
				if (lo_q == '0) begin
					state_d = S_RDP;
				end else if (lo_q >= count_q) begin
					raddr   = AW'(count_q - CW'(1));
					state_d = S_RDP;
				end else begin
					raddr   = AW'(lo_q - CW'(1));
					state_d = S_RDA;
				end
			end
			S_RDP: begin
				state_d = S_IDLE;
			end
			S_RDA: begin
				raddr   = lo_q[AW-1:0];
				state_d = S_RDB;
			end
			S_RDB: begin
				if (rd_dist <= d0_q || gap_now <= {16'b0, epsilon_q}) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				div_in.start = 1'b1;
				div_dvd      = prod_q;
				div_dsr      = gap_q;
				state_d      = S_DIVW;
			end
			S_DIVW: begin
				div_dsr = gap_q;
				if (div_out.done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			total_length_q <= '0;
			entry_count_q  <= '0;
			epsilon_q      <= 16'd1;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL_LENGTH: total_length_q <= cfg_wdata;
					REG_ENTRY_COUNT:  entry_count_q  <= cfg_wdata[10:0];
					REG_EPSILON:      epsilon_q      <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_WRITE || count_in == '0)) begin
						done_q <= 1'b1;
					end
				end
				S_RDP: done_q <= 1'b1;
				S_RDB: begin
					if (rd_dist <= d0_q || gap_now <= {16'b0, epsilon_q}) begin
						done_q <= 1'b1;
					end
				end
				S_DIVW: begin
					if (div_out.done) begin
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					query_q <= query_distance;
					count_q <= count_in;
					lo_q    <= '0;
					hi_q    <= count_in;
					if (command == CMD_WRITE) begin
						param_q  <= '0;
						status_q <= ST_WRITE;
					end else if (count_in == '0) begin
						param_q  <= '0;
						status_q <= ST_EMPTY;
					end else begin
						stat_pend_q <= ST_ZERO_LEN;
					end
				end
			end
			S_WRAP: begin
				if (div_out.done) begin
					if (!query_q[31]) begin
						r_q <= div_rem;
					end else begin
						r_q <= (div_rem == '0) ? '0 : total_length_q - div_rem;
					end
				end
			end
			S_CMP: begin
				if (rd_dist < r_q) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			S_POST: begin
				stat_pend_q <= (lo_q == '0) ? ST_FIRST : ST_LAST;
			end
			S_RDP: begin
				param_q  <= rd_param;
				status_q <= stat_pend_q;
			end
			S_RDA: begin
				d0_q <= rd_dist;
				p0_q <= rd_param;
			end
			S_RDB: begin
				gap_q   <= gap_now;
				num_q   <= r_q - d0_q;
				down_q  <= rd_param < p0_q;
				delta_q <= (rd_param >= p0_q) ? rd_param - p0_q : p0_q - rd_param;
				param_q <= p0_q;
				status_q <= ST_INTERP;
			end
			S_MUL: begin
				prod_q <= delta_q * num_q;
			end
			S_DIVW: begin
				if (div_out.done) begin
					param_q <= down_q ? p0_q - div_quo : p0_q + div_quo;
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign param_out = param_q;
	assign status    = status_q;

	// a write transaction always answers on the next cycle with write status
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_WRITE |=> done && status == ST_WRITE)
		else $error("write transaction without write result");

	// binary search bounds never cross
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK || state_q == S_CMP) |-> lo_q <= hi_q && hi_q <= count_q)
		else $error("search bounds out of order");

	// a result strobe always returns the block to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("result while still busy");

	// a query with a non-empty table never finishes in the accept cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_QUERY && count_in != '0 |=> busy && !done)
		else $error("query finished too early");

endmodule
